FILE: hw/rtl/stpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpl_pkg
// Widths, angle constants and shared types of the segment to polar line block.
// ----------------------------------------------------------------------------
package stpl_pkg;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;

    // coordinate difference and products
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W;
    localparam int CROSS_W = PROD_W;
    localparam int ABSC_W  = CROSS_W - 1;

    // CORDIC datapath: vectors carried at a scale of 2^(60 - COORD_BITS), so the
    // floor shifts of every stage truncate at the same weights
    localparam int NSTAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int CSCALE  = 60 - COORD_BITS;
    localparam int XY_W    = DIFF_W + CSCALE + 2;

    // angles: 32 fraction bits
    localparam int ANG_W = 36;
    localparam logic signed [ANG_W-1:0] ANG_PI         = 36'sd13493037705;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI    = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER_PI = 36'sd3373259426;
    localparam int ANG_SH  = 32 - ANGLE_FRAC_BITS;
    localparam int OANG_W  = 17;

    // root and division
    localparam int ROOT_K  = 31 - COORD_BITS;
    localparam int RAD_W   = 64;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int RT_W    = 33;
    localparam int DIV_W   = RT_W + 1;
    localparam int NUM_W   = ABSC_W + ROOT_K + 2;
    localparam int Q_W     = 17;
    localparam int RHO_W   = 16;
    localparam int LEN_W   = 17;

    // source of phi
    localparam logic [2:0] PHI_CORDIC = 3'd0;
    localparam logic [2:0] PHI_ZERO   = 3'd1;
    localparam logic [2:0] PHI_PI     = 3'd2;
    localparam logic [2:0] PHI_HALF   = 3'd3;
    localparam logic [2:0] PHI_NHALF  = 3'd4;

    localparam logic [ANG_W-1:0] ATAN_TAB [0:10] = '{
        36'd3373259426, 36'd1991351318, 36'd1052175346, 36'd534100635,
        36'd268086748,  36'd134174063,  36'd67103403,   36'd33553749,
        36'd16777131,   36'd8388597,    36'd4194303
    };

    function automatic logic signed [ANG_W-1:0] stage_angle(input int i);
        logic [ANG_W-1:0] a;
        if (i < 11) begin
            a = ATAN_TAB[i];
        end else begin
            a = ANG_W'(1) << (32 - i);
        end
        return signed'(a);
    endfunction

    typedef struct packed {
        logic [SUM_W-1:0]          s;
        logic signed [CROSS_W-1:0] c;
        logic [2:0]                code;
    } t_side;

    typedef struct packed {
        logic [OANG_W-1:0] ang;
        logic              vert;
        logic [ABSC_W-1:0] absc;
        logic              szero;
    } t_tail;

endpackage
`default_nettype wire

FILE: hw/rtl/stpl_seg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpl_seg_if
// Request channel: the two endpoints of one segment.
// ----------------------------------------------------------------------------
interface stpl_seg_if;
    logic        valid;
    logic        ready;
    logic signed [stpl_pkg::COORD_BITS-1:0] start_x;
    logic signed [stpl_pkg::COORD_BITS-1:0] start_y;
    logic signed [stpl_pkg::COORD_BITS-1:0] end_x;
    logic signed [stpl_pkg::COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/stpl_line_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpl_line_if
// Result channel: normal form, orientation and length of one segment.
// ----------------------------------------------------------------------------
interface stpl_line_if;
    logic        valid;
    logic        ready;
    logic signed [stpl_pkg::OANG_W-1:0] normal_angle;
    logic [stpl_pkg::RHO_W-1:0]         normal_distance;
    logic                               is_vertical;
    logic [stpl_pkg::LEN_W-1:0]         segment_length;

    modport source (output valid, normal_angle, normal_distance, is_vertical,
                    segment_length, input ready);
    modport sink   (input valid, normal_angle, normal_distance, is_vertical,
                    segment_length, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/segment_to_polar_line.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_to_polar_line
// Line segment to normal form: angle, distance, orientation and length.
// ----------------------------------------------------------------------------
// One result per request. A request is taken every cycle unless the result
// port stalls; the pipeline is NSTAGES + SQ_STEPS + Q_W + 8 register stages
// long, set by the unrolled CORDIC, the bitwise square root and the restoring
// divider. A stall at the result port holds the whole pipeline, so nothing is
// lost or repeated.
module segment_to_polar_line (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stpl_seg_if.sink   i_seg,
    stpl_line_if.source o_line
);
    localparam int DW = stpl_pkg::DIFF_W;
    localparam int PW = stpl_pkg::PROD_W;
    localparam int AW = stpl_pkg::ANG_W;

    logic w_en;
    logic r_ov;

    assign w_en        = !r_ov || o_line.ready;
    assign i_seg.ready = w_en;

    // stage A: differences
    logic                                   r_av;
    logic signed [stpl_pkg::COORD_BITS-1:0] r_ax1, r_ay1;
    logic signed [DW-1:0]                   r_adx, r_ady;

    // stage B: products
    logic                 r_bv;
    logic signed [PW-1:0] r_bxx, r_byy, r_bc1, r_bc2;
    logic signed [DW-1:0] r_bdx, r_bdy;
    logic signed [stpl_pkg::COORD_BITS-1:0] r_bx1;

    // stage C: squared length, cross product, phi source
    logic                 r_cv;
    logic signed [DW-1:0] r_cdx, r_cdy;
    stpl_pkg::t_side      r_cside;
    stpl_pkg::t_side      n_cside;

    always_comb begin
        n_cside.s = stpl_pkg::SUM_W'(r_bxx) + stpl_pkg::SUM_W'(r_byy);
        if (r_bdx == 0 && r_bdy == 0) begin
            n_cside.c = -stpl_pkg::CROSS_W'(r_bx1);
        end else begin
            n_cside.c = r_bc1 - r_bc2;
        end
        if (r_bdx == 0) begin
            n_cside.code = (r_bdy < 0) ? stpl_pkg::PHI_PI : stpl_pkg::PHI_ZERO;
        end else if (r_bdy == 0) begin
            n_cside.code = (r_bdx > 0) ? stpl_pkg::PHI_HALF : stpl_pkg::PHI_NHALF;
        end else begin
            n_cside.code = stpl_pkg::PHI_CORDIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
        end else if (w_en) begin
            r_av <= i_seg.valid;
            r_bv <= r_av;
            r_cv <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax1   <= i_seg.start_x;
            r_ay1   <= i_seg.start_y;
            r_adx   <= DW'(i_seg.end_x) - DW'(i_seg.start_x);
            r_ady   <= DW'(i_seg.end_y) - DW'(i_seg.start_y);
            r_bxx   <= r_adx * r_adx;
            r_byy   <= r_ady * r_ady;
            r_bc1   <= PW'(r_ay1) * PW'(r_adx);
            r_bc2   <= PW'(r_ax1) * PW'(r_ady);
            r_bdx   <= r_adx;
            r_bdy   <= r_ady;
            r_bx1   <= r_ax1;
            r_cdx   <= r_bdx;
            r_cdy   <= r_bdy;
            r_cside <= n_cside;
        end
    end

    logic                 w_kv;
    logic signed [AW-1:0] w_kz;
    stpl_pkg::t_side      w_kside;

    stpl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_cv),
        .i_dx    (r_cdx),
        .i_dy    (r_cdy),
        .i_side  (r_cside),
        .o_valid (w_kv),
        .o_z     (w_kz),
        .o_side  (w_kside)
    );

    // stage D: phi, theta, rounding, orientation
    logic signed [AW-1:0] n_phi, n_theta, n_rnd;
    stpl_pkg::t_tail      n_tail;
    logic                 r_dv;
    logic [stpl_pkg::SUM_W-1:0] r_ds;
    stpl_pkg::t_tail      r_dtail;

    always_comb begin
        case (w_kside.code)
            stpl_pkg::PHI_ZERO:  n_phi = '0;
            stpl_pkg::PHI_PI:    n_phi = stpl_pkg::ANG_PI;
            stpl_pkg::PHI_HALF:  n_phi = stpl_pkg::ANG_HALF_PI;
            stpl_pkg::PHI_NHALF: n_phi = -stpl_pkg::ANG_HALF_PI;
            default: begin
                if (w_kz > stpl_pkg::ANG_PI) begin
                    n_phi = stpl_pkg::ANG_PI;
                end else if (w_kz <= -stpl_pkg::ANG_PI) begin
                    n_phi = -stpl_pkg::ANG_PI + AW'(1);
                end else begin
                    n_phi = w_kz;
                end
            end
        endcase
        n_theta = (w_kside.c < 0) ? -n_phi : stpl_pkg::ANG_PI - n_phi;
        n_rnd   = n_theta + (AW'(1) <<< (stpl_pkg::ANG_SH - 1));
        n_tail.ang   = n_rnd[stpl_pkg::ANG_SH +: stpl_pkg::OANG_W];
        n_tail.vert  = (n_theta > -stpl_pkg::ANG_QUARTER_PI) &&
                       (n_theta < stpl_pkg::ANG_QUARTER_PI);
        n_tail.absc  = (w_kside.c < 0) ? stpl_pkg::ABSC_W'(-w_kside.c)
                                       : stpl_pkg::ABSC_W'(w_kside.c);
        n_tail.szero = (w_kside.s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_en) begin
            r_dv <= w_kv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds    <= w_kside.s;
            r_dtail <= n_tail;
        end
    end

    logic                          w_rv;
    logic [stpl_pkg::LEN_W-1:0]    w_rlen;
    logic [stpl_pkg::Q_W-1:0]      w_rq;
    logic                          w_rovf;
    stpl_pkg::t_tail               w_rtail;

    stpl_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_dv),
        .i_s     (r_ds),
        .i_tail  (r_dtail),
        .o_valid (w_rv),
        .o_len   (w_rlen),
        .o_q     (w_rq),
        .o_ovf   (w_rovf),
        .o_tail  (w_rtail)
    );

    // output register: saturate rho, zero length for a point
    logic [stpl_pkg::RHO_W-1:0] n_rho;
    logic [stpl_pkg::LEN_W-1:0] n_len;
    logic signed [stpl_pkg::OANG_W-1:0] r_oang;
    logic [stpl_pkg::RHO_W-1:0] r_orho;
    logic                       r_overt;
    logic [stpl_pkg::LEN_W-1:0] r_olen;

    always_comb begin
        if (w_rtail.szero) begin
            n_len = '0;
            if (w_rtail.absc > stpl_pkg::ABSC_W'({stpl_pkg::RHO_W{1'b1}})) begin
                n_rho = '1;
            end else begin
                n_rho = w_rtail.absc[stpl_pkg::RHO_W-1:0];
            end
        end else begin
            n_len = w_rlen;
            if (w_rovf || w_rq[stpl_pkg::Q_W-1]) begin
                n_rho = '1;
            end else begin
                n_rho = w_rq[stpl_pkg::RHO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oang  <= signed'(w_rtail.ang);
            r_orho  <= n_rho;
            r_overt <= w_rtail.vert;
            r_olen  <= n_len;
        end
    end

    assign o_line.valid           = r_ov;
    assign o_line.normal_angle    = r_oang;
    assign o_line.normal_distance = r_orho;
    assign o_line.is_vertical     = r_overt;
    assign o_line.segment_length  = r_olen;
endmodule
`default_nettype wire

FILE: hw/rtl/stpl_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpl_cordic
// Unrolled vectoring CORDIC, one register stage per iteration, giving
// atan2(dx, dy) with 32 fraction bits. Side data travels alongside.
// ----------------------------------------------------------------------------
module stpl_cordic (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic signed [stpl_pkg::DIFF_W-1:0]     i_dx,
    input  wire logic signed [stpl_pkg::DIFF_W-1:0]     i_dy,
    input  wire stpl_pkg::t_side                        i_side,
    output logic                                        o_valid,
    output logic signed [stpl_pkg::ANG_W-1:0]           o_z,
    output stpl_pkg::t_side                             o_side
);
    localparam int N = stpl_pkg::NSTAGES;

    logic                                   r_v    [0:N];
    logic signed [stpl_pkg::XY_W-1:0]       r_x    [0:N];
    logic signed [stpl_pkg::XY_W-1:0]       r_y    [0:N];
    logic signed [stpl_pkg::ANG_W-1:0]      r_z    [0:N];
    stpl_pkg::t_side                        r_side [0:N];

    logic signed [stpl_pkg::XY_W-1:0]  n_x0;
    logic signed [stpl_pkg::XY_W-1:0]  n_y0;
    logic signed [stpl_pkg::ANG_W-1:0] n_z0;

    // fold the left half plane onto the right, starting at plus or minus pi
    always_comb begin
        n_x0 = stpl_pkg::XY_W'(i_dy) <<< stpl_pkg::CSCALE;
        n_y0 = stpl_pkg::XY_W'(i_dx) <<< stpl_pkg::CSCALE;
        n_z0 = '0;
        if (n_x0 < 0) begin
            n_z0 = (n_y0 >= 0) ? stpl_pkg::ANG_PI : -stpl_pkg::ANG_PI;
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [stpl_pkg::XY_W-1:0]  n_x;
        logic signed [stpl_pkg::XY_W-1:0]  n_y;
        logic signed [stpl_pkg::ANG_W-1:0] n_z;

        always_comb begin
            if (r_y[i] >= 0) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + stpl_pkg::stage_angle(i);
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - stpl_pkg::stage_angle(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_side[i+1] <= r_side[i];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_z     = r_z[N];
    assign o_side  = r_side[N];
endmodule
`default_nettype wire

FILE: hw/rtl/stpl_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpl_root
// Pipelined bitwise square root of the scaled squared length, then a
// pipelined restoring division that turns the cross product into rho.
// ----------------------------------------------------------------------------
module stpl_root (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic [stpl_pkg::SUM_W-1:0]         i_s,
    input  wire stpl_pkg::t_tail                    i_tail,
    output logic                                    o_valid,
    output logic [stpl_pkg::LEN_W-1:0]              o_len,
    output logic [stpl_pkg::Q_W-1:0]                o_q,
    output logic                                    o_ovf,
    output stpl_pkg::t_tail                         o_tail
);
    localparam int NS = stpl_pkg::SQ_STEPS;
    localparam int NQ = stpl_pkg::Q_W;

    // square root stages
    logic                            r_sv   [0:NS];
    logic [stpl_pkg::RAD_W-1:0]      r_rad  [0:NS];
    logic [stpl_pkg::RAD_W-1:0]      r_root [0:NS];
    stpl_pkg::t_tail                 r_st   [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= stpl_pkg::RAD_W'(i_s) << (2 * stpl_pkg::ROOT_K);
            r_root[0] <= '0;
            r_st[0]   <= i_tail;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        localparam logic [stpl_pkg::RAD_W-1:0] BITV =
            stpl_pkg::RAD_W'(1) << (stpl_pkg::RAD_W - 2 - 2 * j);
        logic [stpl_pkg::RAD_W-1:0] n_trial;
        logic [stpl_pkg::RAD_W-1:0] n_rad;
        logic [stpl_pkg::RAD_W-1:0] n_root;

        always_comb begin
            n_trial = r_root[j] + BITV;
            if (r_rad[j] >= n_trial) begin
                n_rad  = r_rad[j] - n_trial;
                n_root = (r_root[j] >> 1) + BITV;
            end else begin
                n_rad  = r_rad[j];
                n_root = r_root[j] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j+1]  <= n_rad;
                r_root[j+1] <= n_root;
                r_st[j+1]   <= r_st[j];
            end
        end
    end

    // division set-up: numerator, divisor 2r, overflow and rounded length
    logic [stpl_pkg::RT_W-1:0]  w_r;
    logic [stpl_pkg::NUM_W-1:0] n_num;
    logic [stpl_pkg::DIV_W-1:0] n_div;
    logic                       n_ovf;
    logic [stpl_pkg::RT_W:0]    n_lsum;
    logic [stpl_pkg::LEN_W-1:0] n_len;

    always_comb begin
        w_r    = r_root[NS][stpl_pkg::RT_W-1:0];
        n_num  = (stpl_pkg::NUM_W'(r_st[NS].absc) << (stpl_pkg::ROOT_K + 1))
                 + stpl_pkg::NUM_W'(w_r);
        n_div  = {w_r, 1'b0};
        n_ovf  = n_num >= (stpl_pkg::NUM_W'(n_div) << NQ);
        n_lsum = {1'b0, w_r} + (stpl_pkg::RT_W+1)'(1 << (stpl_pkg::ROOT_K - 1));
        if ((n_lsum >> stpl_pkg::ROOT_K) > (stpl_pkg::RT_W+1)'({stpl_pkg::LEN_W{1'b1}}))
        begin
            n_len = '1;
        end else begin
            n_len = n_lsum[stpl_pkg::ROOT_K +: stpl_pkg::LEN_W];
        end
    end

    logic                         r_dv   [0:NQ];
    logic [stpl_pkg::NUM_W-1:0]   r_rem  [0:NQ];
    logic [stpl_pkg::DIV_W-1:0]   r_div  [0:NQ];
    logic [NQ-1:0]                r_q    [0:NQ];
    logic                         r_ovf  [0:NQ];
    logic [stpl_pkg::LEN_W-1:0]   r_len  [0:NQ];
    stpl_pkg::t_tail              r_dt   [0:NQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_sv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num;
            r_div[0] <= n_div;
            r_q[0]   <= '0;
            r_ovf[0] <= n_ovf;
            r_len[0] <= n_len;
            r_dt[0]  <= r_st[NS];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [stpl_pkg::NUM_W-1:0] w_dsh;
        logic [stpl_pkg::NUM_W-1:0] n_rem;
        logic [NQ-1:0]              n_q;

        always_comb begin
            w_dsh = stpl_pkg::NUM_W'(r_div[k]) << (NQ - 1 - k);
            n_rem = r_rem[k];
            n_q   = r_q[k];
            if (r_rem[k] >= w_dsh) begin
                n_rem            = r_rem[k] - w_dsh;
                n_q[NQ - 1 - k]  = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_div[k+1] <= r_div[k];
                r_q[k+1]   <= n_q;
                r_ovf[k+1] <= r_ovf[k];
                r_len[k+1] <= r_len[k];
                r_dt[k+1]  <= r_dt[k];
            end
        end
    end

    assign o_valid = r_dv[NQ];
    assign o_len   = r_len[NQ];
    assign o_q     = r_q[NQ];
    assign o_ovf   = r_ovf[NQ];
    assign o_tail  = r_dt[NQ];
endmodule
`default_nettype wire
